/* sv/palette_color_dedup_table_core_assert.svh */
// assertion macros for the palette color dedup table
// used by the checker module only, no other dependencies
`ifndef PALETTE_COLOR_DEDUP_TABLE_CORE_ASSERT_SVH
`define PALETTE_COLOR_DEDUP_TABLE_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PCD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcd assertion failed");

// next-cycle implication, disabled during reset
`define PCD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcd assertion failed");

`endif

/* sv/pcd_pkg.sv */
// shared types and constants of the palette color dedup table
// no dependencies
package pcd_pkg;

  // default pen table depth
  localparam int NUM_PENS_DEF = 256;

  // field widths
  localparam int CNT_W   = 16;
  localparam int COLOR_W = 24;
  localparam int PEN_W   = 8;
  localparam int USED_W  = 9;
  localparam int CNT_RST = 256;

  // request commands
  typedef enum logic [1:0] {
    CMD_MAP   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_NEW    = 2'd1,
    STS_FULL   = 2'd2,
    STS_REJECT = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

/* sv/pcd_in_if.sv */
// request channel of the palette color dedup table
// depends on pcd_pkg
interface pcd_in_if;
  import pcd_pkg::*;

  logic       valid;
  logic       ready;
  cmd_t       command;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] entry_index;

  modport source (output valid, command, red, green, blue, entry_index, input ready);
  modport sink   (input valid, command, red, green, blue, entry_index, output ready);
endinterface

/* sv/pcd_out_if.sv */
// result channel of the palette color dedup table
// depends on pcd_pkg
interface pcd_out_if;
  import pcd_pkg::*;

  logic              valid;
  logic              ready;
  logic [PEN_W-1:0]  pen_index;
  status_t           status;
  logic [7:0]        read_red;
  logic [7:0]        read_green;
  logic [7:0]        read_blue;
  logic [USED_W-1:0] used_entries;

  modport source (output valid, pen_index, status, read_red, read_green, read_blue,
                  used_entries, input ready);
  modport sink   (input valid, pen_index, status, read_red, read_green, read_blue,
                  used_entries, output ready);
endinterface

/* sv/palette_color_dedup_table_core.sv */
// palette color dedup table: maps rgb colors onto a pen table
// depends on pcd_pkg, pcd_in_if, pcd_out_if
//
//   channel   dir  handshake    carries
//   in_req    in   valid/ready  command, red, green, blue, entry_index
//   out_res   out  valid/ready  pen_index, status, read rgb, used_entries
//   cfg       in   cfg_we       color_count
//
// identity map, read, write and clear pass from the request registers through the done state to the result register
// dedup map walks the table through the single memory read port, one entry
// a cycle, until a match or the last entry in use
// reset clears the used count, mode register, state and result valid only; the table needs no pass
// a result waits in the output register; the next request is taken meanwhile
module palette_color_dedup_table_core #(
  parameter int NUM_PENS = pcd_pkg::NUM_PENS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  pcd_in_if.sink                   in_req,
  pcd_out_if.source                out_res,
  input  logic                     cfg_we,
  input  logic [pcd_pkg::CNT_W-1:0] cfg_wdata
);
  import pcd_pkg::*;

  localparam int AW   = (NUM_PENS > 1) ? $clog2(NUM_PENS) : 1;
  localparam int CW   = $clog2(NUM_PENS + 1);
  localparam int CMPW = (CW > PEN_W) ? CW : PEN_W;
  localparam int MW   = CNT_W + 1;

  // pen table
  logic [COLOR_W-1:0] mem [NUM_PENS];

  state_t             state_r, state_nxt;
  cmd_t               cmd_r;
  logic [COLOR_W-1:0] rgb_r;
  logic [7:0]         idx_r;
  logic               found_r, found_nxt;
  logic [AW-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic [CW-1:0]      used_r, used_nxt;
  logic [CNT_W-1:0]   cfg_r;
  logic [COLOR_W-1:0] rdata_r;

  logic               out_valid_r;
  logic [PEN_W-1:0]   pen_r;
  status_t            status_r;
  logic [COLOR_W-1:0] rd_r;
  logic [USED_W-1:0]  used_out_r;

  logic               in_fire;
  logic               ident;
  logic               idx_lt_used;
  logic               hit;
  logic               last;
  logic               slot_free;
  logic               commit;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [CMPW-1:0]    pen_val;
  status_t            status_val;
  logic [COLOR_W-1:0] rd_val;

  // common decode
  assign in_fire     = in_req.valid && in_req.ready;
  assign ident       = MW'(cfg_r) <= MW'(NUM_PENS);
  assign idx_lt_used = CMPW'(idx_r) < CMPW'(used_r);
  assign hit         = rdata_r == rgb_r;
  assign last        = (CW'(cmp_idx_r) + CW'(1)) == used_r;
  assign slot_free   = !out_valid_r || out_res.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_req.command == CMD_MAP && !ident && used_r != '0) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (hit || last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs, memory control and result values
  always_comb begin
    in_req.ready = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    mem_we       = 1'b0;
    mem_waddr    = used_r[AW-1:0];
    commit       = 1'b0;
    found_nxt    = found_r;
    cmp_idx_nxt  = cmp_idx_r;
    used_nxt     = used_r;
    pen_val      = '0;
    status_val   = STS_OK;
    rd_val       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_req.ready = 1'b1;
        if (in_fire) begin
          found_nxt   = 1'b0;
          cmp_idx_nxt = '0;
          if (in_req.command == CMD_READ) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(in_req.entry_index);
          end else if (in_req.command == CMD_MAP && !ident && used_r != '0) begin
            mem_re    = 1'b1;
            mem_raddr = '0;
          end
        end
      end
      S_SCAN: begin
        // compare the entry read last cycle, fetch the next one
        if (hit) begin
          found_nxt = 1'b1;
        end else if (!last) begin
          mem_re      = 1'b1;
          mem_raddr   = cmp_idx_r + AW'(1);
          cmp_idx_nxt = cmp_idx_r + AW'(1);
        end
      end
      S_DONE: begin
        commit = slot_free;
        case (cmd_r)
          CMD_MAP: begin
            if (found_r) begin
              pen_val = CMPW'(cmp_idx_r);
            end else if (used_r < CW'(NUM_PENS)) begin
              pen_val    = CMPW'(used_r);
              status_val = STS_NEW;
              mem_we     = slot_free;
              used_nxt   = slot_free ? used_r + CW'(1) : used_r;
            end else begin
              status_val = STS_FULL;
            end
          end
          CMD_READ: begin
            pen_val = CMPW'(idx_r);
            rd_val  = idx_lt_used ? rdata_r : '0;
          end
          CMD_WRITE: begin
            pen_val = CMPW'(idx_r);
            if (ident && idx_lt_used) begin
              mem_we    = slot_free;
              mem_waddr = AW'(idx_r);
            end else begin
              status_val = STS_REJECT;
            end
          end
          default: begin
            used_nxt = slot_free ? '0 : used_r;
          end
        endcase
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      cfg_r       <= CNT_W'(CNT_RST);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and scan payload
  always_ff @(posedge clk) begin
    found_r   <= found_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    if (in_fire) begin
      cmd_r <= in_req.command;
      rgb_r <= {in_req.red, in_req.green, in_req.blue};
      idx_r <= in_req.entry_index;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (commit) begin
      pen_r      <= PEN_W'(pen_val);
      status_r   <= status_val;
      rd_r       <= rd_val;
      used_out_r <= USED_W'(used_nxt);
    end
  end

  // table write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= rgb_r;
    end
  end

  // table read port, registered
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.pen_index    = pen_r;
  assign out_res.status       = status_r;
  assign out_res.read_red     = rd_r[23:16];
  assign out_res.read_green   = rd_r[15:8];
  assign out_res.read_blue    = rd_r[7:0];
  assign out_res.used_entries = used_out_r;

endmodule

/* sv/pcd_checker.sv */
// port-level checks of the palette color dedup table, bound to the top level
// depends on pcd_pkg and palette_color_dedup_table_core_assert.svh
`include "palette_color_dedup_table_core_assert.svh"

module pcd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pcd_pkg::PEN_W-1:0]   pen_index,
  input pcd_pkg::status_t            status,
  input logic [pcd_pkg::USED_W-1:0]  used_entries
);
  import pcd_pkg::*;

  // a pending result is held until taken
  `PCD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)

  // one request at a time: busy right after a request is taken
  `PCD_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready)

  // a full table always reports pen zero
  `PCD_ASSERT_IMP(a_full_pen_zero, out_valid && status == STS_FULL, pen_index == '0)

  // a new entry is the last one in use
  `PCD_ASSERT_IMP(a_new_is_last, out_valid && status == STS_NEW,
                  pen_index == PEN_W'(used_entries - USED_W'(1)))

endmodule

bind palette_color_dedup_table_core pcd_checker u_pcd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_req.valid),
  .in_ready     (in_req.ready),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .pen_index    (out_res.pen_index),
  .status       (out_res.status),
  .used_entries (out_res.used_entries)
);

/* tb/tb_palette_color_dedup_table_core.sv */
// self-checking testbench for palette_color_dedup_table_core: directed table, then random phases
// mirrors the pen table to predict every result; depends on pcd_pkg, pcd_in_if, pcd_out_if
module tb_palette_color_dedup_table_core;
  import pcd_pkg::*;

  localparam int TABLE_DEPTH = NUM_PENS_DEF;
  localparam int N_DIR       = 24;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 300;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] entry_index;
  } pen_req_t;

  typedef struct packed {
    logic [PEN_W-1:0]  pen_index;
    status_t           status;
    logic [7:0]        read_red;
    logic [7:0]        read_green;
    logic [7:0]        read_blue;
    logic [USED_W-1:0] used_entries;
  } pen_result_t;

  // one directed row: optional color_count write, the request, optional typed result
  typedef struct packed {
    bit               cfg_en;
    logic [CNT_W-1:0] cfg_val;
    pen_req_t         rq;
    bit               typed;
    pen_result_t      want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  pcd_in_if  in_req ();
  pcd_out_if out_res ();

  palette_color_dedup_table_core #(.NUM_PENS(TABLE_DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // mirror of the block state
  logic [23:0]      table_mirror [TABLE_DEPTH];
  int               used_mirror;
  logic [CNT_W-1:0] color_count_mirror;
  logic [23:0]      color_pool [8];

  pen_result_t pen_results_due [$];
  dir_row_t    dir_rows [N_DIR];

  int mismatches = 0;
  int stall_cycles = 0;
  int burst_left = 0;
  int cfg_writes = 0;
  int cmd_count [4];
  int status_count [4];
  bit hold_req = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // next table state and result for one request
  function automatic pen_result_t apply_pen_request(input pen_req_t rq);
    pen_result_t res;
    logic [23:0] rgb;
    int          hit;
    bit          ident;
    res = '0;
    res.status = STS_OK;
    rgb = {rq.red, rq.green, rq.blue};
    ident = (color_count_mirror <= TABLE_DEPTH);
    case (rq.command)
      CMD_MAP: begin
        hit = used_mirror;
        // dedup search, lowest matching entry wins
        if (!ident)
          for (int k = used_mirror - 1; k >= 0; k--)
            if (table_mirror[k] == rgb) hit = k;
        if (hit < used_mirror) begin
          res.pen_index = PEN_W'(hit);
        end else if (used_mirror < TABLE_DEPTH) begin
          res.pen_index = PEN_W'(used_mirror);
          table_mirror[used_mirror] = rgb;
          used_mirror++;
          res.status = STS_NEW;
        end else begin
          res.status = STS_FULL;
        end
      end
      CMD_READ: begin
        res.pen_index = rq.entry_index;
        if (rq.entry_index < used_mirror)
          {res.read_red, res.read_green, res.read_blue} = table_mirror[rq.entry_index];
      end
      CMD_WRITE: begin
        res.pen_index = rq.entry_index;
        if (ident && rq.entry_index < used_mirror) table_mirror[rq.entry_index] = rgb;
        else res.status = STS_REJECT;
      end
      default: used_mirror = 0;
    endcase
    res.used_entries = USED_W'(used_mirror);
    return res;
  endfunction

  // random request, biased toward the pool, stored colors and the used range
  function automatic pen_req_t random_request(input int w_map, input int w_read,
                                              input int w_write, input int pool_pct);
    pen_req_t    rq;
    int          roll;
    logic [23:0] rgb;
    roll = $urandom_range(0, 99);
    if (roll < w_map) rq.command = CMD_MAP;
    else if (roll < w_map + w_read) rq.command = CMD_READ;
    else if (roll < w_map + w_read + w_write) rq.command = CMD_WRITE;
    else rq.command = CMD_CLEAR;
    if ($urandom_range(0, 99) < pool_pct) begin
      if (used_mirror > 0 && $urandom_range(0, 1) == 1)
        rgb = table_mirror[$urandom_range(0, used_mirror - 1)];
      else
        rgb = color_pool[$urandom_range(0, 7)];
    end else begin
      rgb = 24'($urandom);
    end
    {rq.red, rq.green, rq.blue} = rgb;
    if ($urandom_range(0, 9) < 7 && used_mirror < TABLE_DEPTH)
      rq.entry_index = 8'($urandom_range(0, used_mirror));
    else
      rq.entry_index = 8'($urandom_range(0, 255));
    return rq;
  endfunction

  // offer one request in bursts with random gaps, record the expected result
  task automatic offer_request(input pen_req_t rq, input bit typed, input pen_result_t want);
    pen_result_t due;
    int          gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_req.valid       <= 1'b1;
    in_req.command     <= rq.command;
    in_req.red         <= rq.red;
    in_req.green       <= rq.green;
    in_req.blue        <= rq.blue;
    in_req.entry_index <= rq.entry_index;
    do @(posedge clk); while (in_req.ready !== 1'b1);
    due = apply_pen_request(rq);
    if (typed) due = want;
    pen_results_due.push_back(due);
    cmd_count[rq.command]++;
  endtask

  // color_count write once the block is idle
  task automatic write_color_count(input logic [CNT_W-1:0] val);
    in_req.valid <= 1'b0;
    while (pen_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    color_count_mirror = val;
    cfg_writes++;
    burst_left = 0;
  endtask

  // one random phase under a fixed color_count
  task automatic run_phase(input logic [CNT_W-1:0] val, input int n_req, input int w_map,
                           input int w_read, input int w_write, input int pool_pct,
                           input bit clear_first, input bit hold_off);
    pen_req_t rq;
    write_color_count(val);
    for (int p = 0; p < 8; p++) color_pool[p] = 24'($urandom);
    if (hold_off) hold_req = 1'b1;
    if (clear_first) begin
      rq = random_request(0, 0, 0, 0);
      offer_request(rq, 1'b0, '0);
    end
    repeat (n_req) begin
      rq = random_request(w_map, w_read, w_write, pool_pct);
      offer_request(rq, 1'b0, '0);
    end
  endtask

  // receiver: stall pattern changes by segment, plus one long hold-off on request
  initial begin
    int mode;
    int left;
    int tick;
    int hold_left;
    bit rdy;
    left = 0;
    tick = 0;
    hold_left = 0;
    mode = 0;
    out_res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 120);
      end
      left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (mode)
          0: rdy = 1'b1;
          1: rdy = ($urandom_range(0, 99) >= 30);
          2: rdy = ((tick % 7) >= 3);
          default: rdy = ($urandom_range(0, 99) >= 80);
        endcase
      end
      out_res.ready <= rdy;
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin : result_check
    pen_result_t got;
    pen_result_t due;
    if (rst_n === 1'b1 && out_res.valid === 1'b1 && out_res.ready === 1'b1) begin
      got = '{out_res.pen_index, out_res.status, out_res.read_red, out_res.read_green,
              out_res.read_blue, out_res.used_entries};
      status_count[got.status]++;
      if (pen_results_due.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] unexpected result: pen %0d status %0d used %0d", $realtime,
                   got.pen_index, got.status, got.used_entries);
        mismatches++;
      end else begin
        due = pen_results_due.pop_front();
        if (got.pen_index !== due.pen_index || got.status !== due.status ||
            got.read_red !== due.read_red || got.read_green !== due.read_green ||
            got.read_blue !== due.read_blue || got.used_entries !== due.used_entries) begin
          if (mismatches < 10) begin
            $display("[%0t] mismatch: expected pen %0d st %0d rgb %h%h%h used %0d",
                     $realtime, due.pen_index, due.status, due.read_red, due.read_green,
                     due.read_blue, due.used_entries);
            $display("[%0t]           got pen %0d st %0d rgb %h%h%h used %0d",
                     $realtime, got.pen_index, got.status, got.read_red, got.read_green,
                     got.read_blue, got.used_entries);
          end
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_req.valid === 1'b1 && in_req.ready === 1'b1) ||
        (out_res.valid === 1'b1 && out_res.ready === 1'b1))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results due", STALL_LIMIT,
               pen_results_due.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_req.valid       = 1'b0;
    in_req.command     = CMD_MAP;
    in_req.red         = '0;
    in_req.green       = '0;
    in_req.blue        = '0;
    in_req.entry_index = '0;
    for (int c = 0; c < 4; c++) begin
      cmd_count[c] = 0;
      status_count[c] = 0;
    end
    for (int e = 0; e < TABLE_DEPTH; e++) table_mirror[e] = '0;
    used_mirror = 0;
    color_count_mirror = CNT_W'(CNT_RST);

    // directed rows: reset color_count first, then dedup at the extremes
    dir_rows = '{
      // read on empty table, both index extremes
      '{1'b0, 16'd0, '{CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00},
        1'b1, '{8'h00, STS_OK, 8'h00, 8'h00, 8'h00, 9'd0}},
      '{1'b0, 16'd0, '{CMD_READ, 8'hff, 8'hff, 8'hff, 8'hff},
        1'b1, '{8'hff, STS_OK, 8'h00, 8'h00, 8'h00, 9'd0}},
      // write beyond used count
      '{1'b0, 16'd0, '{CMD_WRITE, 8'hff, 8'hff, 8'hff, 8'h00},
        1'b1, '{8'h00, STS_REJECT, 8'h00, 8'h00, 8'h00, 9'd0}},
      '{1'b0, 16'd0, '{CMD_CLEAR, 8'h55, 8'h55, 8'h55, 8'haa},
        1'b1, '{8'h00, STS_OK, 8'h00, 8'h00, 8'h00, 9'd0}},
      // identity mode appends duplicates too
      '{1'b0, 16'd0, '{CMD_MAP, 8'h00, 8'h00, 8'h00, 8'hff},
        1'b1, '{8'h00, STS_NEW, 8'h00, 8'h00, 8'h00, 9'd1}},
      '{1'b0, 16'd0, '{CMD_MAP, 8'hff, 8'hff, 8'hff, 8'h00},
        1'b1, '{8'h01, STS_NEW, 8'h00, 8'h00, 8'h00, 9'd2}},
      '{1'b0, 16'd0, '{CMD_MAP, 8'hff, 8'hff, 8'hff, 8'h00},
        1'b1, '{8'h02, STS_NEW, 8'h00, 8'h00, 8'h00, 9'd3}},
      '{1'b0, 16'd0, '{CMD_READ, 8'h00, 8'h00, 8'h00, 8'h01},
        1'b1, '{8'h01, STS_OK, 8'hff, 8'hff, 8'hff, 9'd3}},
      '{1'b0, 16'd0, '{CMD_WRITE, 8'h12, 8'h34, 8'h56, 8'h02},
        1'b1, '{8'h02, STS_OK, 8'h00, 8'h00, 8'h00, 9'd3}},
      '{1'b0, 16'd0, '{CMD_READ, 8'h00, 8'h00, 8'h00, 8'h02},
        1'b1, '{8'h02, STS_OK, 8'h12, 8'h34, 8'h56, 9'd3}},
      // index equal to used count: write rejected, read black
      '{1'b0, 16'd0, '{CMD_WRITE, 8'h77, 8'h77, 8'h77, 8'h03},
        1'b1, '{8'h03, STS_REJECT, 8'h00, 8'h00, 8'h00, 9'd3}},
      '{1'b0, 16'd0, '{CMD_READ, 8'h00, 8'h00, 8'h00, 8'h03},
        1'b1, '{8'h03, STS_OK, 8'h00, 8'h00, 8'h00, 9'd3}},
      '{1'b0, 16'd0, '{CMD_MAP, 8'ha5, 8'h5a, 8'hc3, 8'h00},
        1'b0, '{8'h00, STS_OK, 8'h00, 8'h00, 8'h00, 9'd0}},
      '{1'b0, 16'd0, '{CMD_MAP, 8'h80, 8'h01, 8'h7f, 8'h00},
        1'b0, '{8'h00, STS_OK, 8'h00, 8'h00, 8'h00, 9'd0}},
      '{1'b0, 16'd0, '{CMD_READ, 8'h00, 8'h00, 8'h00, 8'h04},
        1'b0, '{8'h00, STS_OK, 8'h00, 8'h00, 8'h00, 9'd0}},
      // clear, then stale entry reads black
      '{1'b0, 16'd0, '{CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00},
        1'b1, '{8'h00, STS_OK, 8'h00, 8'h00, 8'h00, 9'd0}},
      '{1'b0, 16'd0, '{CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00},
        1'b1, '{8'h00, STS_OK, 8'h00, 8'h00, 8'h00, 9'd0}},
      '{1'b0, 16'd0, '{CMD_MAP, 8'h00, 8'hff, 8'h00, 8'h00},
        1'b1, '{8'h00, STS_NEW, 8'h00, 8'h00, 8'h00, 9'd1}},
      // dedup at the largest color_count: match, append, match
      '{1'b1, 16'hffff, '{CMD_MAP, 8'h00, 8'hff, 8'h00, 8'h00},
        1'b1, '{8'h00, STS_OK, 8'h00, 8'h00, 8'h00, 9'd1}},
      '{1'b0, 16'd0, '{CMD_MAP, 8'h01, 8'hff, 8'h00, 8'h00},
        1'b1, '{8'h01, STS_NEW, 8'h00, 8'h00, 8'h00, 9'd2}},
      '{1'b0, 16'd0, '{CMD_MAP, 8'h01, 8'hff, 8'h00, 8'h00},
        1'b1, '{8'h01, STS_OK, 8'h00, 8'h00, 8'h00, 9'd2}},
      // write refused in dedup mode even inside the used range
      '{1'b0, 16'd0, '{CMD_WRITE, 8'hff, 8'h00, 8'hff, 8'h00},
        1'b1, '{8'h00, STS_REJECT, 8'h00, 8'h00, 8'h00, 9'd2}},
      '{1'b0, 16'd0, '{CMD_READ, 8'h00, 8'h00, 8'h00, 8'h01},
        1'b1, '{8'h01, STS_OK, 8'h01, 8'hff, 8'h00, 9'd2}},
      // smallest dedup color_count
      '{1'b1, 16'd257, '{CMD_MAP, 8'h00, 8'hff, 8'h00, 8'h00},
        1'b1, '{8'h00, STS_OK, 8'h00, 8'h00, 8'h00, 9'd2}}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].cfg_en) write_color_count(dir_rows[i].cfg_val);
      offer_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
    end

    // zero color_count counts as identity
    run_phase(16'd0, 60, 45, 25, 25, 30, 1'b0, 1'b0);
    // dedup with heavy reuse, receiver holds off at the start
    run_phase(16'hffff, 100, 60, 15, 15, 60, 1'b0, 1'b1);
    // identity fill until the table is full
    run_phase(16'd1, 290, 94, 3, 3, 20, 1'b1, 1'b0);
    // dedup fill with mostly new colors, long searches near full
    run_phase(16'd257, 300, 94, 3, 3, 5, 1'b1, 1'b0);
    run_phase(CNT_W'($urandom_range(2, 65535)), 60, 50, 20, 20, 40, 1'b0, 1'b0);

    // drain
    in_req.valid <= 1'b0;
    while (pen_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pen_results_due.size() != 0) mismatches += pen_results_due.size();

    $display("summary: %0d requests (map %0d, read %0d, write %0d, clear %0d), %0d cfg writes",
             cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3], cmd_count[CMD_MAP],
             cmd_count[CMD_READ], cmd_count[CMD_WRITE], cmd_count[CMD_CLEAR], cfg_writes);
    $display("summary: status ok %0d, new %0d, full %0d, rejected %0d; %0d mismatches",
             status_count[STS_OK], status_count[STS_NEW], status_count[STS_FULL],
             status_count[STS_REJECT], mismatches);
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
